// ===== hw/rtl/chte_pkg.sv =====
// Shared types and constants for the chained hash table engine.
// Holds the request and response structs, operation and status codes,
// and the fixed widths. Depends on nothing.
package chte_pkg;

	// Key and hash geometry.
	localparam int CHAR_W    = 8;
	localparam int KEY_CHARS = 9;
	localparam int KEY_W     = CHAR_W * KEY_CHARS;
	localparam int LOW_W     = 64;
	localparam int HASH_W    = 32;

	// Hash unit step counter: counts the key characters down to zero.
	localparam int HASH_CNT_W = $clog2(KEY_CHARS + 1);

	// Remainder unit: eight dividend bits per step.
	localparam int MOD_STEP_BITS = 8;
	localparam int MOD_STEPS     = HASH_W / MOD_STEP_BITS;
	localparam int MOD_CNT_W     = $clog2(MOD_STEPS + 1);

	// Configuration registers.
	localparam int COUNT_W    = 7;
	localparam int BASE_W     = 8;
	localparam int CFG_DATA_W = 8;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_HASH_BASE    = CFG_IDX_W'(1);

	localparam logic [COUNT_W-1:0] BUCKET_COUNT_RESET = COUNT_W'(64);
	localparam logic [BASE_W-1:0]  HASH_BASE_RESET    = BASE_W'(7);

	// Width of the reported bucket index.
	localparam int BUCKET_IDX_W = 6;

	// Operation codes; the unused code behaves as a search.
	typedef enum logic [1:0] {
		OP_SEARCH = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2
	} op_e;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_ABSENT = 2'd1,
		ST_DUP    = 2'd2,
		ST_FULL   = 2'd3
	} status_e;

	// One request.
	typedef struct packed {
		logic [1:0]        op;
		logic [LOW_W-1:0]  key_low_chars;
		logic [CHAR_W-1:0] key_last_char;
	} req_t;

	// One result.
	typedef struct packed {
		logic                    found;
		logic [BUCKET_IDX_W-1:0] bucket_index;
		logic [1:0]              status;
	} rsp_t;

endpackage

// ===== hw/rtl/chained_hash_table_engine_top.sv =====
// Top level of the chained hash table engine: controller, match logic and
// configuration registers. Depends on chte_pkg, chte_hash, chte_mod, chte_store.
//
// The engine serves one search, insert or delete at a time. A request is taken
// when start is high and busy is low; its result appears on rsp with done high
// for exactly one cycle and cannot be held off. busy falls in that same cycle,
// so a new request can already be taken then. A request passes through the
// hash unit (nine serial multiply-adds of 32 by 8 bits), the remainder unit
// (four steps of eight bits), one registered row read of the bucket store and
// the match and row write-back. After reset the valid memory is cleared one
// row at a time, during which busy is high; configuration writes are taken
// at any time but belong between requests.
module chained_hash_table_engine_top
	import chte_pkg::*;
#(
	parameter int NUM_BUCKETS  = 64,
	parameter int BUCKET_SLOTS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  req_t                  req,
	output logic                  done,
	output rsp_t                  rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int ROW_W = BUCKET_SLOTS * KEY_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_HASH,
		S_MOD,
		S_MATCH
	} state_t;

	state_t               state_q;
	logic                 done_q;
	rsp_t                 rsp_q;
	req_t                 req_q;
	logic [COUNT_W-1:0]   rem_q;
	logic [COUNT_W-1:0]   bucket_count_q;
	logic [BASE_W-1:0]    hash_base_q;

	logic                 accept;
	logic                 clearing;
	logic                 hash_done;
	logic [HASH_W-1:0]    hash_val;
	logic                 mod_start;
	logic                 mod_done;
	logic [COUNT_W-1:0]   mod_rem;
	logic [COUNT_W-1:0]   eff_count;
	logic [AW+COUNT_W-1:0] rd_addr_ext;
	logic [AW+COUNT_W-1:0] wr_addr_ext;
	logic                 rd_en;
	logic [ROW_W-1:0]     rd_key;
	logic [BUCKET_SLOTS-1:0] rd_valid;
	logic [KEY_W-1:0]     req_key;

	logic [BUCKET_SLOTS-1:0] hit_vec;
	logic [BUCKET_SLOTS-1:0] free_vec;
	logic [BUCKET_SLOTS-1:0] hit_oh;
	logic [BUCKET_SLOTS-1:0] free_oh;
	logic                    hit;
	logic                    has_free;
	logic [ROW_W-1:0]        key_wdata;
	logic [BUCKET_SLOTS-1:0] valid_wdata;
	logic                    key_we;
	logic                    valid_we;
	logic [1:0]              status_d;

	assign accept  = start && !busy;
	assign busy    = (state_q != S_IDLE) || clearing;
	assign req_key = {req_q.key_last_char, req_q.key_low_chars};

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BUCKET_COUNT_RESET;
			hash_base_q    <= HASH_BASE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BUCKET_COUNT: bucket_count_q <= cfg_data[COUNT_W-1:0];
				CFG_HASH_BASE:    hash_base_q    <= cfg_data[BASE_W-1:0];
				default:          ;
			endcase
		end
	end

	// Bucket count in use: zero means one, and the count saturates at the table size.
	always_comb begin
		if (bucket_count_q == '0) begin
			eff_count = COUNT_W'(1);
		end else if (int'(bucket_count_q) > NUM_BUCKETS) begin
			eff_count = COUNT_W'(NUM_BUCKETS);
		end else begin
			eff_count = bucket_count_q;
		end
	end

	// Hash and remainder units.
	chte_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.base   (hash_base_q),
		.key    ({req.key_last_char, req.key_low_chars}),
		.done   (hash_done),
		.hash   (hash_val)
	);

	assign mod_start = (state_q == S_HASH) && hash_done;

	chte_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (hash_val),
		.divisor  (eff_count),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// Row read is issued as soon as the bucket is known.
	assign rd_en       = (state_q == S_MOD) && mod_done;
	assign rd_addr_ext = {{AW{1'b0}}, mod_rem};
	assign wr_addr_ext = {{AW{1'b0}}, rem_q};

	chte_store #(
		.NUM_BUCKETS  (NUM_BUCKETS),
		.BUCKET_SLOTS (BUCKET_SLOTS)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr_ext[AW-1:0]),
		.rd_key      (rd_key),
		.rd_valid    (rd_valid),
		.wr_addr     (wr_addr_ext[AW-1:0]),
		.key_we      (key_we),
		.key_wdata   (key_wdata),
		.valid_we    (valid_we),
		.valid_wdata (valid_wdata),
		.clearing    (clearing)
	);

	// Slot match over the row just read, and the lowest hit and free slots.
	always_comb begin
		for (int s = 0; s < BUCKET_SLOTS; s++) begin
			hit_vec[s] = rd_valid[s] && (rd_key[s*KEY_W +: KEY_W] == req_key);
		end
		free_vec = ~rd_valid;
		hit_oh   = hit_vec & (~hit_vec + BUCKET_SLOTS'(1));
		free_oh  = free_vec & (~free_vec + BUCKET_SLOTS'(1));
		hit      = |hit_vec;
		has_free = |free_vec;
	end

	// Row write-back data: the key goes into the lowest free slot.
	always_comb begin
		for (int s = 0; s < BUCKET_SLOTS; s++) begin
			key_wdata[s*KEY_W +: KEY_W] = free_oh[s] ? req_key : rd_key[s*KEY_W +: KEY_W];
		end
		if (req_q.op == OP_INSERT) begin
			valid_wdata = rd_valid | free_oh;
		end else begin
			valid_wdata = rd_valid & ~hit_oh;
		end
	end

	// Store updates and the status of the request.
	always_comb begin
		key_we   = 1'b0;
		valid_we = 1'b0;
		case (req_q.op)
			OP_INSERT: begin
				if (hit) begin
					status_d = ST_DUP;
				end else if (!has_free) begin
					status_d = ST_FULL;
				end else begin
					status_d = ST_DONE;
					key_we   = (state_q == S_MATCH);
					valid_we = (state_q == S_MATCH);
				end
			end
			OP_DELETE: begin
				if (hit) begin
					status_d = ST_DONE;
					valid_we = (state_q == S_MATCH);
				end else begin
					status_d = ST_ABSENT;
				end
			end
			default: begin
				status_d = hit ? ST_DONE : ST_ABSENT;
			end
		endcase
	end

	// Request sequencer with the registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (hash_done) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (mod_done) begin
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					state_q            <= S_IDLE;
					done_q             <= 1'b1;
					rsp_q.found        <= hit;
					rsp_q.bucket_index <= rem_q[BUCKET_IDX_W-1:0];
					rsp_q.status       <= status_d;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request payload and bucket number.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (rd_en) begin
			rem_q <= mod_rem;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	// A request yields a single result strobe.
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	// A transfer makes the engine busy for the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("engine not busy after a request transfer");

	// No request is taken while the valid memory is still being cleared.
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> busy)
		else $error("engine idle during the clearing sweep");

	// A duplicate insert always reports the key as found.
	a_dup_found: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp_q.status == ST_DUP)) |-> rsp_q.found)
		else $error("duplicate reported without a hit");

	// A full bucket is never reported together with a hit.
	a_full_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp_q.status == ST_FULL)) |-> !rsp_q.found)
		else $error("full bucket reported with a hit");
`endif

endmodule

// ===== hw/rtl/chte_hash.sv =====
// Polynomial key hash, evaluated in Horner form one character per cycle.
// Starts from the last key character and works down through all KEY_CHARS characters.
// Depends on chte_pkg.
module chte_hash
	import chte_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [BASE_W-1:0] base,
	input  logic [KEY_W-1:0]  key,
	output logic              done,
	output logic [HASH_W-1:0] hash
);

	logic [HASH_W-1:0]     acc_q;
	logic [KEY_W-1:0]      key_q;
	logic [BASE_W-1:0]     base_q;
	logic [HASH_CNT_W-1:0] cnt_q;
	logic                  done_q;
	logic [HASH_W-1:0]     prod;
	logic [HASH_W-1:0]     acc_d;

	// One multiply-add: acc * base + next character, modulo 2^32.
	assign prod  = acc_q * HASH_W'(base_q);
	assign acc_d = prod + HASH_W'(key_q[KEY_W-1 -: CHAR_W]);

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= HASH_CNT_W'(KEY_CHARS);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - HASH_CNT_W'(1);
				done_q <= (cnt_q == HASH_CNT_W'(1));
			end
		end
	end

	// Accumulator and character shift register; the top byte is consumed first.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= '0;
			key_q  <= key;
			base_q <= base;
		end else if (cnt_q != '0) begin
			acc_q <= acc_d;
			key_q <= {key_q[KEY_W-CHAR_W-1:0], {CHAR_W{1'b0}}};
		end
	end

	assign done = done_q;
	assign hash = acc_q;

endmodule

// ===== hw/rtl/chte_mod.sv =====
// Remainder of the 32-bit hash by the bucket count, restoring style.
// Eight dividend bits are retired per cycle, over MOD_STEPS steps.
// Depends on chte_pkg.
module chte_mod
	import chte_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [HASH_W-1:0]  dividend,
	input  logic [COUNT_W-1:0] divisor,
	output logic               done,
	output logic [COUNT_W-1:0] rem
);

	logic [HASH_W-1:0]    div_q;
	logic [COUNT_W-1:0]   dsr_q;
	logic [COUNT_W-1:0]   rem_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [HASH_W-1:0]    div_d;
	logic [COUNT_W-1:0]   rem_d;

	// Eight shift and conditional subtract steps on the narrow partial remainder.
	always_comb begin
		logic [COUNT_W:0]  r;
		logic [HASH_W-1:0] d;
		r = {1'b0, rem_q};
		d = div_q;
		for (int i = 0; i < MOD_STEP_BITS; i++) begin
			r = {r[COUNT_W-1:0], d[HASH_W-1]};
			d = {d[HASH_W-2:0], 1'b0};
			if (r >= {1'b0, dsr_q}) begin
				r = r - {1'b0, dsr_q};
			end
		end
		div_d = d;
		rem_d = r[COUNT_W-1:0];
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= MOD_CNT_W'(MOD_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - MOD_CNT_W'(1);
				done_q <= (cnt_q == MOD_CNT_W'(1));
			end
		end
	end

	// Dividend shift register and partial remainder.
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			div_q <= div_d;
			rem_q <= rem_d;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ===== hw/rtl/chte_store.sv =====
// Bucket store: one row per bucket in a key memory and a valid-mask memory.
// Both have one registered read port and one write port; the valid memory is
// swept to zero after reset, one row per cycle. Depends on chte_pkg.
module chte_store
	import chte_pkg::*;
#(
	parameter int NUM_BUCKETS  = 64,
	parameter int BUCKET_SLOTS = 8
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              rd_en,
	input  logic [$clog2((NUM_BUCKETS > 1) ? NUM_BUCKETS : 2)-1:0] rd_addr,
	output logic [BUCKET_SLOTS*KEY_W-1:0]                     rd_key,
	output logic [BUCKET_SLOTS-1:0]                           rd_valid,
	input  logic [$clog2((NUM_BUCKETS > 1) ? NUM_BUCKETS : 2)-1:0] wr_addr,
	input  logic                                              key_we,
	input  logic [BUCKET_SLOTS*KEY_W-1:0]                     key_wdata,
	input  logic                                              valid_we,
	input  logic [BUCKET_SLOTS-1:0]                           valid_wdata,
	output logic                                              clearing
);

	localparam int AW    = $clog2((NUM_BUCKETS > 1) ? NUM_BUCKETS : 2);
	localparam int ROW_W = BUCKET_SLOTS * KEY_W;

	logic [ROW_W-1:0]        key_mem   [NUM_BUCKETS];
	logic [BUCKET_SLOTS-1:0] valid_mem [NUM_BUCKETS];
	logic [ROW_W-1:0]        rd_key_q;
	logic [BUCKET_SLOTS-1:0] rd_valid_q;
	logic [AW-1:0]           clr_addr_q;
	logic                    clearing_q;

	// Clearing sweep over the valid rows after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			if (clr_addr_q == AW'(NUM_BUCKETS - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	// Key memory.
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[wr_addr] <= key_wdata;
		end
		if (rd_en) begin
			rd_key_q <= key_mem[rd_addr];
		end
	end

	// Valid-mask memory; the clearing sweep owns the write port while it runs.
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			valid_mem[clr_addr_q] <= '0;
		end else if (valid_we) begin
			valid_mem[wr_addr] <= valid_wdata;
		end
		if (rd_en) begin
			rd_valid_q <= valid_mem[rd_addr];
		end
	end

	assign rd_key   = rd_key_q;
	assign rd_valid = rd_valid_q;
	assign clearing = clearing_q;

endmodule
